// ===== design/psfp_pkg.sv =====
package psfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4d;

  localparam int FIELD_COUNT = 9;
  localparam logic [8:0] FIELD_FIRST = 9'd10;
  localparam logic [8:0] FIELD_END   = 9'd28;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_GAIN       = 2'd0;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd1;
  localparam logic [1:0] REG_PM25_CAP   = 2'd2;
  localparam logic [1:0] REG_COUNT_CAP  = 2'd3;

  localparam logic [15:0] GAIN_RESET       = 16'd256;
  localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd200;
  localparam logic [15:0] PM25_CAP_RESET   = 16'd5000;
  localparam logic [15:0] COUNT_CAP_RESET  = 16'd9999;

  typedef struct packed {
    logic        frame_good;
    logic [15:0] pm1_0;
    logic [15:0] pm2_5;
    logic [15:0] pm10;
    logic [15:0] count_0p3;
    logic [15:0] count_0p5;
    logic [15:0] count_1p0;
    logic [15:0] count_2p5;
    logic [15:0] count_5p0;
    logic [15:0] count_10p0;
  } result_t;

  // q8.8 scale with truncation, saturate at 16 bits, optional clamp
  function automatic logic [15:0] scale_value(input logic [15:0] raw,
                                              input logic [15:0] gain,
                                              input logic [15:0] cap,
                                              input logic        capped);
    logic [31:0] prod;
    logic [15:0] v;
    prod = {16'd0, raw} * {16'd0, gain};
    v = (prod[31:24] != 8'd0) ? 16'hffff : prod[23:8];
    if (capped && (v > cap)) begin
      v = cap;
    end
    return v;
  endfunction

endpackage

// ===== design/particle_sensor_frame_parser.sv =====
// a result is registered from the byte that completes its frame, into skid if the output stalls
// throughput: one request (byte or tick) per cycle while in_stall is low; the completing byte's path holds
//   the nine parallel q8.8 multiply lanes, which set the clock
// a two-deep output (result register plus skid) lets input continue under out_stall until the skid holds a result
// reset: synchronous active-low rst_n; control and state registers return to defaults, out_r/skid_r data do not
module particle_sensor_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_good,
  output logic [15:0] out_pm1_0,
  output logic [15:0] out_pm2_5,
  output logic [15:0] out_pm10,
  output logic [15:0] out_count_0p3,
  output logic [15:0] out_count_0p5,
  output logic [15:0] out_count_1p0,
  output logic [15:0] out_count_2p5,
  output logic [15:0] out_count_5p0,
  output logic [15:0] out_count_10p0,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import psfp_pkg::*;

  logic [15:0] gain_r;
  logic [7:0]  idle_limit_r;
  logic [15:0] pm25_cap_r;
  logic [15:0] count_cap_r;

  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [15:0] check_r, check_nxt;
  logic [7:0]  idle_r, idle_nxt;
  logic [15:0] raw_r [FIELD_COUNT];
  logic [15:0] raw_nxt [FIELD_COUNT];
  logic [15:0] pub_r [FIELD_COUNT];
  logic [15:0] pub_nxt [FIELD_COUNT];

  result_t out_r, skid_r, res;
  logic    out_v_r, skid_v_r;
  logic    res_v;

  logic        accept;
  logic [8:0]  pos_inc;
  logic [8:0]  rel;
  logic [7:0]  len_eff;
  logic [7:0]  tick_cnt;
  logic [15:0] sum_before;
  logic        frame_end;
  logic        good;
  logic        out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_v_r;
  assign out_free = !out_v_r || !out_stall;

  assign pos_inc    = pos_r + 9'd1;
  assign rel        = pos_r - FIELD_FIRST;
  assign len_eff    = (pos_r == 9'd3) ? in_rx_byte : len_r;
  assign tick_cnt   = idle_r + 8'd1;
  // sum of all bytes but the last two: the new byte is not yet in sum_r, the previous one is check_r[7:0]
  assign sum_before = sum_r - {8'd0, check_r[7:0]};

  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    check_nxt = check_r;
    idle_nxt  = idle_r;
    raw_nxt   = raw_r;
    frame_end = 1'b0;
    if (accept) begin
      if (in_op == OP_TICK) begin
        if (tick_cnt > idle_limit_r) begin
          idle_nxt = 8'd0;
          pos_nxt  = 9'd0;
        end else begin
          idle_nxt = tick_cnt;
        end
      end else begin
        idle_nxt = 8'd0;
        priority if (pos_r == 9'd0) begin
          if (in_rx_byte == HDR_FIRST) begin
            sum_nxt   = {8'd0, in_rx_byte};
            check_nxt = {8'd0, in_rx_byte};
            pos_nxt   = 9'd1;
          end
        end else if (pos_r == 9'd1) begin
          if (in_rx_byte == HDR_SECOND) begin
            sum_nxt   = sum_r + {8'd0, in_rx_byte};
            check_nxt = {check_r[7:0], in_rx_byte};
            pos_nxt   = 9'd2;
          end else begin
            pos_nxt = 9'd0;
          end
        end else begin
          sum_nxt   = sum_r + {8'd0, in_rx_byte};
          check_nxt = {check_r[7:0], in_rx_byte};
          if ((pos_r >= FIELD_FIRST) && (pos_r < FIELD_END)) begin
            if (rel[0]) begin
              raw_nxt[rel[4:1]][7:0] = in_rx_byte;
            end else begin
              raw_nxt[rel[4:1]][15:8] = in_rx_byte;
            end
          end
          if (pos_r == 9'd3) begin
            len_nxt = in_rx_byte;
          end
          pos_nxt = pos_inc;
          if ((pos_r >= 9'd3) && ({1'b0, pos_inc} >= (10'd4 + {2'd0, len_eff}))) begin
            frame_end = 1'b1;
            pos_nxt   = 9'd0;
          end
        end
      end
    end
  end

  assign good  = (sum_before == check_nxt);
  assign res_v = frame_end;

  always_comb begin
    pub_nxt = pub_r;
    if (frame_end && good) begin
      for (int i = 0; i < FIELD_COUNT; i++) begin
        if (i == 1) begin
          pub_nxt[i] = scale_value(raw_nxt[i], gain_r, pm25_cap_r, 1'b1);
        end else if (i == 0 || i == 2) begin
          pub_nxt[i] = scale_value(raw_nxt[i], gain_r, count_cap_r, 1'b0);
        end else begin
          pub_nxt[i] = scale_value(raw_nxt[i], gain_r, count_cap_r, 1'b1);
        end
      end
    end
  end

  always_comb begin
    res.frame_good = good;
    res.pm1_0      = pub_nxt[0];
    res.pm2_5      = pub_nxt[1];
    res.pm10       = pub_nxt[2];
    res.count_0p3  = pub_nxt[3];
    res.count_0p5  = pub_nxt[4];
    res.count_1p0  = pub_nxt[5];
    res.count_2p5  = pub_nxt[6];
    res.count_5p0  = pub_nxt[7];
    res.count_10p0 = pub_nxt[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= GAIN_RESET;
      idle_limit_r <= IDLE_LIMIT_RESET;
      pm25_cap_r   <= PM25_CAP_RESET;
      count_cap_r  <= COUNT_CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:       gain_r       <= cfg_data;
        REG_IDLE_LIMIT: idle_limit_r <= cfg_data[7:0];
        REG_PM25_CAP:   pm25_cap_r   <= cfg_data;
        REG_COUNT_CAP:  count_cap_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 9'd0;
      len_r   <= 8'd0;
      sum_r   <= 16'd0;
      check_r <= 16'd0;
      idle_r  <= 8'd0;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        raw_r[i] <= 16'd0;
        pub_r[i] <= 16'd0;
      end
    end else begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      check_r <= check_nxt;
      idle_r  <= idle_nxt;
      raw_r   <= raw_nxt;
      pub_r   <= pub_nxt;
    end
  end

  // result register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        out_r    <= skid_r;
        skid_v_r <= res_v;
        skid_r   <= res;
      end else begin
        out_v_r <= res_v;
        out_r   <= res;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
      skid_r   <= res;
    end
  end

  assign out_valid      = out_v_r;
  assign out_frame_good = out_r.frame_good;
  assign out_pm1_0      = out_r.pm1_0;
  assign out_pm2_5      = out_r.pm2_5;
  assign out_pm10       = out_r.pm10;
  assign out_count_0p3  = out_r.count_0p3;
  assign out_count_0p5  = out_r.count_0p5;
  assign out_count_1p0  = out_r.count_1p0;
  assign out_count_2p5  = out_r.count_2p5;
  assign out_count_5p0  = out_r.count_5p0;
  assign out_count_10p0 = out_r.count_10p0;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_fills_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_v_r && out_free) |=> !skid_v_r)
    else $error("skid filled although the output was free");

  a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_TICK) && !skid_v_r && out_free) |=> !out_v_r)
    else $error("a timer tick produced a result");

  a_hunt_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_TICK) && (tick_cnt > idle_limit_r)) |=> (pos_r == 9'd0))
    else $error("idle timeout did not restart the header hunt");

endmodule

// ===== tb/particle_sensor_frame_parser_tb.sv =====
`timescale 1ns / 100ps

module particle_sensor_frame_parser_tb;
  import psfp_pkg::*;

  // frame parse predictor plus the queue of results it still owes
  class particle_frame_checker;
    logic [15:0] gain;
    logic [7:0]  idle_limit;
    logic [15:0] pm25_cap;
    logic [15:0] count_cap;

    logic [8:0]  hunt_pos;
    logic [7:0]  frame_len;
    logic [15:0] byte_sum;
    logic [15:0] last_two;
    logic [15:0] raw[FIELD_COUNT];
    logic [15:0] pub[FIELD_COUNT];
    logic [7:0]  idle_ticks;

    result_t expected_frames[$];
    int      frames_predicted;
    int      frames_checked;
    int      mismatches;

    function new();
      gain       = GAIN_RESET;
      idle_limit = IDLE_LIMIT_RESET;
      pm25_cap   = PM25_CAP_RESET;
      count_cap  = COUNT_CAP_RESET;
      hunt_pos   = '0;
      frame_len  = '0;
      byte_sum   = '0;
      last_two   = '0;
      idle_ticks = '0;
      foreach (raw[i]) begin
        raw[i] = '0;
        pub[i] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_GAIN:       gain = data;
        REG_IDLE_LIMIT: idle_limit = data[7:0];
        REG_PM25_CAP:   pm25_cap = data;
        REG_COUNT_CAP:  count_cap = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] scaled(logic [15:0] raw_val, logic [15:0] cap, bit capped);
      logic [31:0] prod;
      logic [15:0] v;
      prod = (32'(raw_val) * 32'(gain)) >> 8;
      v = (prod > 32'h0000ffff) ? 16'hffff : prod[15:0];
      if (capped && v > cap) v = cap;
      return v;
    endfunction

    function void note_request(logic op, logic [7:0] b);
      logic [8:0]  cur_pos;
      logic [9:0]  frame_end;
      logic [15:0] sum_before;
      result_t     r;
      int          rel;
      if (op == OP_TICK) begin
        idle_ticks = idle_ticks + 8'd1;
        if (idle_ticks > idle_limit) begin
          idle_ticks = '0;
          hunt_pos = '0;
        end
        return;
      end
      idle_ticks = '0;
      cur_pos = hunt_pos;
      if (cur_pos == 9'd0) begin
        if (b == HDR_FIRST) begin
          byte_sum = {8'd0, b};
          last_two = {8'd0, b};
          hunt_pos = 9'd1;
        end
        return;
      end
      if (cur_pos == 9'd1) begin
        if (b == HDR_SECOND) begin
          byte_sum = byte_sum + b;
          last_two = {last_two[7:0], b};
          hunt_pos = 9'd2;
        end else begin
          hunt_pos = 9'd0;
        end
        return;
      end
      byte_sum = byte_sum + b;
      last_two = {last_two[7:0], b};
      // field bytes land even when they turn out to be checksum bytes
      if (cur_pos >= FIELD_FIRST && cur_pos < FIELD_END) begin
        rel = cur_pos - FIELD_FIRST;
        if (rel % 2) raw[rel / 2][7:0] = b;
        else raw[rel / 2][15:8] = b;
      end
      if (cur_pos == 9'd3) frame_len = b;
      hunt_pos = cur_pos + 9'd1;
      frame_end = 10'd4 + frame_len;
      if (cur_pos < 9'd3 || {1'b0, hunt_pos} < frame_end) return;
      hunt_pos = '0;
      sum_before = byte_sum - last_two[15:8] - last_two[7:0];
      if (sum_before == last_two) begin
        pub[0] = scaled(raw[0], 16'd0, 1'b0);
        pub[1] = scaled(raw[1], pm25_cap, 1'b1);
        pub[2] = scaled(raw[2], 16'd0, 1'b0);
        for (int i = 3; i < FIELD_COUNT; i++) pub[i] = scaled(raw[i], count_cap, 1'b1);
      end
      r.frame_good = (sum_before == last_two);
      r.pm1_0      = pub[0];
      r.pm2_5      = pub[1];
      r.pm10       = pub[2];
      r.count_0p3  = pub[3];
      r.count_0p5  = pub[4];
      r.count_1p0  = pub[5];
      r.count_2p5  = pub[6];
      r.count_5p0  = pub[7];
      r.count_10p0 = pub[8];
      expected_frames.push_back(r);
      frames_predicted++;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_frame(result_t got);
      result_t     want;
      logic [15:0] g[10];
      logic [15:0] w[10];
      string       names[10];
      names = '{"frame_good", "pm1_0", "pm2_5", "pm10", "count_0p3", "count_0p5",
                "count_1p0", "count_2p5", "count_5p0", "count_10p0"};
      if (expected_frames.size() == 0) begin
        report("result arrived with no frame pending");
        return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      g = '{{15'd0, got.frame_good}, got.pm1_0, got.pm2_5, got.pm10, got.count_0p3,
            got.count_0p5, got.count_1p0, got.count_2p5, got.count_5p0, got.count_10p0};
      w = '{{15'd0, want.frame_good}, want.pm1_0, want.pm2_5, want.pm10, want.count_0p3,
            want.count_0p5, want.count_1p0, want.count_2p5, want.count_5p0, want.count_10p0};
      for (int k = 0; k < 10; k++) begin
        if (g[k] !== w[k])
          report($sformatf("frame %0d %s: got %h, expected %h",
                           frames_checked, names[k], g[k], w[k]));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_BYTE;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_frame_good;
  logic [15:0] out_pm1_0;
  logic [15:0] out_pm2_5;
  logic [15:0] out_pm10;
  logic [15:0] out_count_0p3;
  logic [15:0] out_count_0p5;
  logic [15:0] out_count_1p0;
  logic [15:0] out_count_2p5;
  logic [15:0] out_count_5p0;
  logic [15:0] out_count_10p0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GAIN;
  logic [15:0] cfg_data = 16'd0;

  particle_frame_checker sb;
  result_t seen_frame;

  int snd_pct = 0;
  int rcv_pct = 0;
  int tick_pct = 0;
  int snd_quiet = 0;
  int rcv_quiet = 0;
  int items_sent = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  particle_sensor_frame_parser DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_good (out_frame_good),
    .out_pm1_0      (out_pm1_0),
    .out_pm2_5      (out_pm2_5),
    .out_pm10       (out_pm10),
    .out_count_0p3  (out_count_0p3),
    .out_count_0p5  (out_count_0p5),
    .out_count_1p0  (out_count_1p0),
    .out_count_2p5  (out_count_2p5),
    .out_count_5p0  (out_count_5p0),
    .out_count_10p0 (out_count_10p0),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls with quiet stretches, or one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rcv_quiet > 0) rcv_quiet--;
      else if ($urandom_range(63) == 0) rcv_quiet = $urandom_range(40, 10);
      out_stall <= (rcv_quiet == 0) && ($urandom_range(99) < rcv_pct);
    end
  end

  // inputs only move at posedge, so the negedge sees what the next edge takes
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_frame.frame_good = out_frame_good;
      seen_frame.pm1_0      = out_pm1_0;
      seen_frame.pm2_5      = out_pm2_5;
      seen_frame.pm10       = out_pm10;
      seen_frame.count_0p3  = out_count_0p3;
      seen_frame.count_0p5  = out_count_0p5;
      seen_frame.count_1p0  = out_count_1p0;
      seen_frame.count_2p5  = out_count_2p5;
      seen_frame.count_5p0  = out_count_5p0;
      seen_frame.count_10p0 = out_count_10p0;
      sb.check_frame(seen_frame);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] b);
    bit taken;
    if (snd_quiet > 0) snd_quiet--;
    else if ($urandom_range(63) == 0) snd_quiet = $urandom_range(40, 10);
    if (snd_quiet == 0) begin
      while ($urandom_range(99) < snd_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    sb.note_request(op, b);
    items_sent++;
  endtask

  // fill: 0 mixed extremes and random, 1 all zero, 2 all ones
  task automatic send_frame(input int len, input int fill, input bit corrupt);
    logic [7:0]  fr[$];
    logic [15:0] s;
    int          k;
    fr = {HDR_FIRST, HDR_SECOND, 8'd0, 8'(len)};
    if ($urandom_range(7) == 0) fr[2] = 8'($urandom);
    for (k = 4; k < len + 4; k++) begin
      case (fill)
        1: fr.push_back(8'h00);
        2: fr.push_back(8'hff);
        default:
          case ($urandom_range(3))
            0: fr.push_back(8'h00);
            1: fr.push_back(8'hff);
            default: fr.push_back(8'($urandom));
          endcase
      endcase
    end
    if (len >= 2) begin
      s = '0;
      for (k = 0; k < len + 2; k++) s = s + fr[k];
      fr[len + 2] = s[15:8];
      fr[len + 3] = s[7:0];
      if (corrupt) begin
        k = $urandom_range(len + 3, 4);
        fr[k] = fr[k] ^ (8'd1 << $urandom_range(7));
      end
    end
    foreach (fr[i]) begin
      if ($urandom_range(99) < tick_pct) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, fr[i]);
    end
  endtask

  task automatic wait_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_frames.size() != 0);
    // a request that gives no result may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] g, input logic [7:0] il,
                            input logic [15:0] p, input logic [15:0] c);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{REG_GAIN, REG_IDLE_LIMIT, REG_PM25_CAP, REG_COUNT_CAP};
    // junk in the upper byte of the idle limit write must be ignored
    val = '{g, {8'($urandom), il}, p, c};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int min_items, input int min_frames);
    int start_items;
    int start_frames;
    int pick;
    start_items = items_sent;
    start_frames = sb.frames_predicted;
    while (items_sent - start_items < min_items ||
           sb.frames_predicted - start_frames < min_frames) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame($urandom_range(1) ? 28 : $urandom_range(28, 2), 0, 1'b0);
      end else if (pick < 65) begin
        send_frame($urandom_range(30, 2), 0, 1'b1);
      end else if (pick < 75) begin
        // header and part of a body, then (idle limit below 40) silence long enough to restart the hunt
        send_item(OP_BYTE, HDR_FIRST);
        send_item(OP_BYTE, HDR_SECOND);
        repeat ($urandom_range(12, 1)) send_item(OP_BYTE, 8'($urandom));
        if (sb.idle_limit < 40) repeat (sb.idle_limit + 1) send_item(OP_TICK, 8'($urandom));
      end else if (pick < 85) begin
        repeat ($urandom_range(6, 1)) send_item(OP_BYTE, 8'($urandom));
      end else if (pick < 93) begin
        repeat ($urandom_range(8, 1)) send_item(OP_TICK, 8'($urandom));
      end else if (pick < 97) begin
        send_frame($urandom_range(1), 0, 1'b0);
      end else begin
        send_frame($urandom_range(255, 200), 0, 1'b0);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at reset settings
    send_item(OP_TICK, 8'hff);
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, HDR_SECOND);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h00);
    // repeated first header byte drops the hunt, so the 4d is just noise
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, HDR_SECOND);
    send_frame(28, 2, 1'b0);
    send_frame(28, 1, 1'b0);
    send_frame(28, 0, 1'b0);
    send_frame(28, 2, 1'b1);
    send_frame(6, 0, 1'b0);
    send_frame(1, 0, 1'b0);
    tick_pct = 20;
    send_frame(28, 0, 1'b0);
    tick_pct = 3;

    for (int ph = 0; ph < 5; ph++) begin
      wait_empty();
      case (ph)
        0: begin
          write_regs(16'd256, 8'd255, 16'hffff, 16'hffff);
          snd_pct = 0;
          rcv_pct = 0;
        end
        1: begin
          write_regs(16'hffff, 8'd1, 16'd0, 16'd0);
          snd_pct = 50;
          rcv_pct = 0;
        end
        2: begin
          write_regs(16'($urandom_range(1023, 1)), 8'($urandom_range(8, 2)),
                     16'($urandom_range(65535)), 16'($urandom_range(65535)));
          snd_pct = 0;
          rcv_pct = 50;
        end
        3: begin
          write_regs(16'd0, 8'd200, 16'd5000, 16'd9999);
          snd_pct = 32;
          rcv_pct = 32;
        end
        default: begin
          write_regs(16'($urandom_range(65535)), 8'($urandom_range(255, 1)),
                     16'($urandom_range(65535)), 16'($urandom_range(65535)));
          snd_pct = 0;
          rcv_pct = 0;
          // long receiver hold-off while requests keep coming
          @(negedge clk);
          hold_req = 1'b1;
          @(posedge clk);
        end
      endcase
      random_traffic(110, 3);
    end

    wait_empty();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
